// ----- hdl/rrc_pkg.sv -----
package rrc_pkg;

   localparam int COEF_COUNT = 21;
   localparam int FRAC       = 20;
   localparam int Q16_SHIFT  = 2 * FRAC - 16;
   localparam int DIV_ITER   = 32;
   localparam int DIV_LAT    = DIV_ITER + 4;
   localparam int FLIGHT_W   = 8;

   typedef logic [4:0] coef_idx_type;

   localparam coef_idx_type IDX_R0 = 5'd0;
   localparam coef_idx_type IDX_R1 = 5'd1;
   localparam coef_idx_type IDX_R2 = 5'd2;
   localparam coef_idx_type IDX_R3 = 5'd3;
   localparam coef_idx_type IDX_R4 = 5'd4;
   localparam coef_idx_type IDX_R5 = 5'd5;
   localparam coef_idx_type IDX_R6 = 5'd6;
   localparam coef_idx_type IDX_R7 = 5'd7;
   localparam coef_idx_type IDX_R8 = 5'd8;
   localparam coef_idx_type IDX_FX = 5'd9;
   localparam coef_idx_type IDX_FY = 5'd10;
   localparam coef_idx_type IDX_CX = 5'd11;
   localparam coef_idx_type IDX_CY = 5'd12;
   localparam coef_idx_type IDX_FU = 5'd13;
   localparam coef_idx_type IDX_FV = 5'd14;
   localparam coef_idx_type IDX_CU = 5'd15;
   localparam coef_idx_type IDX_CV = 5'd16;
   localparam coef_idx_type IDX_K1 = 5'd17;
   localparam coef_idx_type IDX_K2 = 5'd18;
   localparam coef_idx_type IDX_P1 = 5'd19;
   localparam coef_idx_type IDX_P2 = 5'd20;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_MAP   = 1'b1;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [31:0] val;
      logic               ovf;
   } sat_type;

   function automatic logic signed [63:0] mul32(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      return 64'(a) * 64'(b);
   endfunction

   function automatic sat_type sat32(input logic signed [63:0] v);
      sat_type r;
      if (v > 64'(S32_MAX)) begin
         r.val = S32_MAX;
         r.ovf = 1'b1;
      end else if (v < 64'(S32_MIN)) begin
         r.val = S32_MIN;
         r.ovf = 1'b1;
      end else begin
         r.val = v[31:0];
         r.ovf = 1'b0;
      end
      return r;
   endfunction

   // round half up and drop FRAC fraction bits of a Q40 product, leaving Q20
   function automatic logic signed [63-FRAC:0] rnd20(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p + (64'sd1 <<< (FRAC - 1));
      return t[63:FRAC];
   endfunction

   function automatic sat_type qsat(input logic signed [63:0] p);
      return sat32(64'(rnd20(p)));
   endfunction

   function automatic sat_type sat2(input logic signed [31:0] v);
      return sat32(64'(v) <<< 1);
   endfunction

   function automatic sat_type sum3(input logic signed [31:0] a,
                                    input logic signed [31:0] b,
                                    input logic signed [31:0] c);
      return sat32(64'(a) + 64'(b) + 64'(c));
   endfunction

   function automatic sat_type toq16(input logic signed [63:0] p,
                                     input logic signed [31:0] c);
      logic signed [63:0]          t;
      logic signed [63-Q16_SHIFT:0] v;
      t = p + (64'(c) <<< FRAC) + (64'sd1 <<< (Q16_SHIFT - 1));
      v = t[63:Q16_SHIFT];
      return sat32(64'(v));
   endfunction

endpackage

// ----- hdl/rrc_div.sv -----
module rrc_div import rrc_pkg::*; #(
   parameter int NUM_W = 33
) (
   input  logic                    clock,
   input  logic signed [NUM_W-1:0] num_in,
   input  logic signed [31:0]      den_in,
   output logic signed [31:0]      quo_out,
   output logic                    ovf_out
);

   localparam int DW = NUM_W + FRAC + 1;
   localparam int HW = DW - 32;
   localparam int CW = (HW > 32) ? HW : 32;

   typedef struct packed {
      logic neg;
      logic dz;
      logic nz;
      logic npos;
   } flag_type;

   logic [NUM_W-1:0] un_a_ff;
   logic [31:0]      ud_a_ff;
   flag_type         fl_a_ff;
   logic [DW-1:0]    d_b_ff;
   logic [31:0]      ud_b_ff;
   flag_type         fl_b_ff;
   logic [HW-1:0]    hi;

   logic [31:0] rem_ff [DIV_ITER+1];
   logic [31:0] low_ff [DIV_ITER+1];
   logic [31:0] q_ff   [DIV_ITER+1];
   logic [31:0] ud_ff  [DIV_ITER+1];
   flag_type    fl_ff  [DIV_ITER+1];
   logic        big_ff [DIV_ITER+1];

   logic signed [31:0] quo_ff;
   logic               ovf_ff;
   logic signed [31:0] quo_in;
   logic               ovf_in;

   // magnitudes and sign
   always_ff @(posedge clock) begin
      un_a_ff      <= num_in[NUM_W-1] ? -num_in : num_in;
      ud_a_ff      <= den_in[31] ? -den_in : den_in;
      fl_a_ff.neg  <= num_in[NUM_W-1] ^ den_in[31];
      fl_a_ff.dz   <= (den_in == '0);
      fl_a_ff.nz   <= (num_in == '0);
      fl_a_ff.npos <= !num_in[NUM_W-1] && (num_in != '0);
   end

   // scaled dividend plus half the divisor for rounding
   always_ff @(posedge clock) begin
      d_b_ff  <= {1'b0, un_a_ff, FRAC'(0)} + DW'(ud_a_ff >> 1);
      ud_b_ff <= ud_a_ff;
      fl_b_ff <= fl_a_ff;
   end

   assign hi = d_b_ff[DW-1:32];

   always_ff @(posedge clock) begin
      big_ff[0] <= (CW'(hi) >= CW'(ud_b_ff));
      rem_ff[0] <= (CW'(hi) >= CW'(ud_b_ff)) ? '0 : 32'(hi);
      low_ff[0] <= d_b_ff[31:0];
      q_ff[0]   <= '0;
      ud_ff[0]  <= ud_b_ff;
      fl_ff[0]  <= fl_b_ff;
   end

   for (genvar i = 0; i < DIV_ITER; i++) begin : g_iter
      logic [32:0] trial;
      logic        ge;
      always_comb begin
         trial = {rem_ff[i], low_ff[i][31]};
         ge    = (trial >= {1'b0, ud_ff[i]});
      end
      always_ff @(posedge clock) begin
         rem_ff[i+1] <= ge ? 32'(trial - {1'b0, ud_ff[i]}) : trial[31:0];
         low_ff[i+1] <= {low_ff[i][30:0], 1'b0};
         q_ff[i+1]   <= {q_ff[i][30:0], ge};
         ud_ff[i+1]  <= ud_ff[i];
         fl_ff[i+1]  <= fl_ff[i];
         big_ff[i+1] <= big_ff[i];
      end
   end

   always_comb begin
      if (fl_ff[DIV_ITER].dz) begin
         ovf_in = 1'b1;
         if (fl_ff[DIV_ITER].npos) begin
            quo_in = S32_MAX;
         end else if (fl_ff[DIV_ITER].nz) begin
            quo_in = '0;
         end else begin
            quo_in = S32_MIN;
         end
      end else if (big_ff[DIV_ITER] ||
                   (!fl_ff[DIV_ITER].neg && q_ff[DIV_ITER][31]) ||
                   (fl_ff[DIV_ITER].neg && (q_ff[DIV_ITER] > 32'h8000_0000))) begin
         ovf_in = 1'b1;
         quo_in = fl_ff[DIV_ITER].neg ? S32_MIN : S32_MAX;
      end else begin
         ovf_in = 1'b0;
         quo_in = fl_ff[DIV_ITER].neg ? -q_ff[DIV_ITER] : q_ff[DIV_ITER];
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign quo_out = quo_ff;
   assign ovf_out = ovf_ff;

endmodule

// ----- hdl/rectify_remap_coordinate_unit.sv -----
// Rectified-to-raw pixel coordinate mapper, one pixel per clock cycle sustained.
// A map transaction reaches its result strobe through two divider passes in
// series; each pass resolves its quotient one bit per iteration stage.
// A coefficient write is held off (busy) until all map transactions in flight drain.
// Synchronous active-high reset clears all valid bits and the coefficient table.
// The receiver cannot stall: each result is shown for exactly one cycle.
module rectify_remap_coordinate_unit import rrc_pkg::*; #(
   parameter int IMAGE_WIDTH_MAX  = 2048,
   parameter int IMAGE_HEIGHT_MAX = 2048
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_mode,
   input  logic [4:0]         req_coef_index,
   input  logic signed [31:0] req_coef_value,
   input  logic [10:0]        req_pixel_col,
   input  logic [10:0]        req_pixel_row,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_source_col,
   output logic signed [31:0] rsp_source_row,
   output logic               rsp_invalid
);

   typedef logic signed [31:0] q_type;
   typedef logic signed [63:0] p_type;

   typedef struct packed { logic [10:0] col; logic [10:0] row; } a_type;
   typedef struct packed { logic signed [32:0] nx; logic signed [32:0] ny; logic oob; } b_type;
   typedef struct packed { p_type p0, p1, p2, p3, p4, p5; logic ovf; } c_type;
   typedef struct packed { q_type rx, ry, rz; logic ovf; } d_type;
   typedef struct packed { q_type x, y; p_type pxx, pyy, pxy; logic ovf, zero; } e_type;
   typedef struct packed { q_type x, y, xx, yy, xy; logic ovf, zero; } f_type;
   typedef struct packed { q_type x, y, xx, yy, xy, r2; logic ovf, zero; } g_type;
   typedef struct packed {
      q_type x, y, r2, ax, ay; p_type pk1, pk2, pp1, pp2; logic ovf, zero;
   } h_type;
   typedef struct packed {
      q_type x, y, r2, ax, ay, k1r2, k2r2, p1xy, p2xy; logic ovf, zero;
   } i_type;
   typedef struct packed {
      q_type x, y, k1r2, dp1, dp2; p_type pt, pax, pay; logic ovf, zero;
   } j_type;
   typedef struct packed { q_type x, y, k1r2, dp1, dp2, t, pax, pay; logic ovf, zero; } k_type;
   typedef struct packed { q_type x, y, radial, dp1, dp2, pax, pay; logic ovf, zero; } l_type;
   typedef struct packed { p_type pxr, pyr; q_type dp1, dp2, pax, pay; logic ovf, zero; } m_type;
   typedef struct packed { q_type xr, yr, dp1, dp2, pax, pay; logic ovf, zero; } n_type;
   typedef struct packed { q_type xd, yd; logic ovf, zero; } o_type;
   typedef struct packed { p_type pc, pr; logic ovf, zero; } pp_type;

   // coefficient table
   q_type coef_ff [COEF_COUNT];

   logic                accept;
   logic                map_acc;
   logic                wr_acc;
   logic [FLIGHT_W-1:0] flight_ff;
   logic [FLIGHT_W-1:0] flight_in;

   logic va_ff, vb_ff, vc_ff, vd_ff, ve_ff, vf_ff, vg_ff, vh_ff;
   logic vi_ff, vj_ff, vk_ff, vl_ff, vm_ff, vn_ff, vo_ff, vp_ff;
   logic [DIV_LAT-1:0] dl1_v_ff, dl1_o_ff, dl2_v_ff, dl2_o_ff, dl2_z_ff;

   a_type  a_ff, a_in;
   b_type  b_ff, b_in;
   c_type  c_ff, c_in;
   d_type  d_ff, d_in;
   e_type  e_ff, e_in;
   f_type  f_ff, f_in;
   g_type  g_ff, g_in;
   h_type  h_ff, h_in;
   i_type  i_ff, i_in;
   j_type  j_ff, j_in;
   k_type  k_ff, k_in;
   l_type  l_ff, l_in;
   m_type  m_ff, m_in;
   n_type  n_ff, n_in;
   o_type  o_ff, o_in;
   pp_type p_ff, p_in;

   q_type xn, yn, xq, yq;
   logic  xn_ovf, yn_ovf, xq_ovf, yq_ovf;

   logic  strobe_ff;
   q_type col_ff, row_ff, col_in, row_in;
   logic  inv_ff, inv_in;

   // Hold coefficient writes while any map transaction is in flight, so that
   // every stage reads the table as it stood when its transaction was accepted.
   assign busy    = (flight_ff != '0) && (req_mode == MODE_WRITE);
   assign accept  = start && !busy;
   assign map_acc = accept && (req_mode == MODE_MAP);
   assign wr_acc  = accept && (req_mode == MODE_WRITE);

   assign flight_in = flight_ff + FLIGHT_W'(map_acc) - FLIGHT_W'(strobe_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < COEF_COUNT; k++) begin
            coef_ff[k] <= '0;
         end
      end else if (wr_acc && (req_coef_index < 5'(COEF_COUNT))) begin
         coef_ff[req_coef_index] <= req_coef_value;
      end
   end

   // Valid bits travel with the data; drop nothing, the receiver never stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         flight_ff <= '0;
         va_ff     <= 1'b0;
         vb_ff     <= 1'b0;
         dl1_v_ff  <= '0;
         vc_ff     <= 1'b0;
         vd_ff     <= 1'b0;
         dl2_v_ff  <= '0;
         ve_ff     <= 1'b0;
         vf_ff     <= 1'b0;
         vg_ff     <= 1'b0;
         vh_ff     <= 1'b0;
         vi_ff     <= 1'b0;
         vj_ff     <= 1'b0;
         vk_ff     <= 1'b0;
         vl_ff     <= 1'b0;
         vm_ff     <= 1'b0;
         vn_ff     <= 1'b0;
         vo_ff     <= 1'b0;
         vp_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         flight_ff <= flight_in;
         va_ff     <= map_acc;
         vb_ff     <= va_ff;
         dl1_v_ff  <= {dl1_v_ff[DIV_LAT-2:0], vb_ff};
         vc_ff     <= dl1_v_ff[DIV_LAT-1];
         vd_ff     <= vc_ff;
         dl2_v_ff  <= {dl2_v_ff[DIV_LAT-2:0], vd_ff};
         ve_ff     <= dl2_v_ff[DIV_LAT-1];
         vf_ff     <= ve_ff;
         vg_ff     <= vf_ff;
         vh_ff     <= vg_ff;
         vi_ff     <= vh_ff;
         vj_ff     <= vi_ff;
         vk_ff     <= vj_ff;
         vl_ff     <= vk_ff;
         vm_ff     <= vl_ff;
         vn_ff     <= vm_ff;
         vo_ff     <= vn_ff;
         vp_ff     <= vo_ff;
         strobe_ff <= vp_ff;
      end
   end

   // capture the pixel position
   always_comb begin
      a_in.col = req_pixel_col;
      a_in.row = req_pixel_row;
   end

   // centre the position ahead of the division by the focal lengths
   always_comb begin
      b_in.nx  = $signed({2'b00, a_ff.col, FRAC'(0)}) - 33'(coef_ff[IDX_CX]);
      b_in.ny  = $signed({2'b00, a_ff.row, FRAC'(0)}) - 33'(coef_ff[IDX_CY]);
      b_in.oob = (32'(a_ff.col) >= 32'(IMAGE_WIDTH_MAX)) ||
                 (32'(a_ff.row) >= 32'(IMAGE_HEIGHT_MAX));
   end

   rrc_div #(.NUM_W(33)) u_div_xn (
      .clock   (clock),
      .num_in  (b_ff.nx),
      .den_in  (coef_ff[IDX_FX]),
      .quo_out (xn),
      .ovf_out (xn_ovf)
   );

   rrc_div #(.NUM_W(33)) u_div_yn (
      .clock   (clock),
      .num_in  (b_ff.ny),
      .den_in  (coef_ff[IDX_FY]),
      .quo_out (yn),
      .ovf_out (yn_ovf)
   );

   // transposed rotation: products first
   always_comb begin
      c_in.p0  = mul32(coef_ff[IDX_R0], xn);
      c_in.p1  = mul32(coef_ff[IDX_R3], yn);
      c_in.p2  = mul32(coef_ff[IDX_R1], xn);
      c_in.p3  = mul32(coef_ff[IDX_R4], yn);
      c_in.p4  = mul32(coef_ff[IDX_R2], xn);
      c_in.p5  = mul32(coef_ff[IDX_R5], yn);
      c_in.ovf = dl1_o_ff[DIV_LAT-1] || xn_ovf || yn_ovf;
   end

   // round each product, then sum with the third column and saturate once
   always_comb begin
      sat_type sx, sy, sz;
      sx = sat32(64'(rnd20(c_ff.p0)) + 64'(rnd20(c_ff.p1)) + 64'(coef_ff[IDX_R6]));
      sy = sat32(64'(rnd20(c_ff.p2)) + 64'(rnd20(c_ff.p3)) + 64'(coef_ff[IDX_R7]));
      sz = sat32(64'(rnd20(c_ff.p4)) + 64'(rnd20(c_ff.p5)) + 64'(coef_ff[IDX_R8]));
      d_in.rx  = sx.val;
      d_in.ry  = sy.val;
      d_in.rz  = sz.val;
      d_in.ovf = c_ff.ovf || sx.ovf || sy.ovf || sz.ovf;
   end

   rrc_div #(.NUM_W(32)) u_div_x (
      .clock   (clock),
      .num_in  (d_ff.rx),
      .den_in  (d_ff.rz),
      .quo_out (xq),
      .ovf_out (xq_ovf)
   );

   rrc_div #(.NUM_W(32)) u_div_y (
      .clock   (clock),
      .num_in  (d_ff.ry),
      .den_in  (d_ff.rz),
      .quo_out (yq),
      .ovf_out (yq_ovf)
   );

   // squares and cross term
   always_comb begin
      e_in.x    = xq;
      e_in.y    = yq;
      e_in.pxx  = mul32(xq, xq);
      e_in.pyy  = mul32(yq, yq);
      e_in.pxy  = mul32(xq, yq);
      e_in.ovf  = dl2_o_ff[DIV_LAT-1] || xq_ovf || yq_ovf;
      e_in.zero = dl2_z_ff[DIV_LAT-1];
   end

   always_comb begin
      sat_type sxx, syy, sxy;
      sxx = qsat(e_ff.pxx);
      syy = qsat(e_ff.pyy);
      sxy = qsat(e_ff.pxy);
      f_in.x    = e_ff.x;
      f_in.y    = e_ff.y;
      f_in.xx   = sxx.val;
      f_in.yy   = syy.val;
      f_in.xy   = sxy.val;
      f_in.ovf  = e_ff.ovf || sxx.ovf || syy.ovf || sxy.ovf;
      f_in.zero = e_ff.zero;
   end

   always_comb begin
      sat_type sr2;
      sr2 = sat32(64'(f_ff.xx) + 64'(f_ff.yy));
      g_in.x    = f_ff.x;
      g_in.y    = f_ff.y;
      g_in.xx   = f_ff.xx;
      g_in.yy   = f_ff.yy;
      g_in.xy   = f_ff.xy;
      g_in.r2   = sr2.val;
      g_in.ovf  = f_ff.ovf || sr2.ovf;
      g_in.zero = f_ff.zero;
   end

   // radial and tangential products; tangential arguments r2 + 2x^2, r2 + 2y^2
   always_comb begin
      sat_type sax, say;
      sax = sat32(64'(g_ff.r2) + (64'(g_ff.xx) <<< 1));
      say = sat32(64'(g_ff.r2) + (64'(g_ff.yy) <<< 1));
      h_in.x    = g_ff.x;
      h_in.y    = g_ff.y;
      h_in.r2   = g_ff.r2;
      h_in.ax   = sax.val;
      h_in.ay   = say.val;
      h_in.pk1  = mul32(coef_ff[IDX_K1], g_ff.r2);
      h_in.pk2  = mul32(coef_ff[IDX_K2], g_ff.r2);
      h_in.pp1  = mul32(coef_ff[IDX_P1], g_ff.xy);
      h_in.pp2  = mul32(coef_ff[IDX_P2], g_ff.xy);
      h_in.ovf  = g_ff.ovf || sax.ovf || say.ovf;
      h_in.zero = g_ff.zero;
   end

   always_comb begin
      sat_type s1, s2, s3, s4;
      s1 = qsat(h_ff.pk1);
      s2 = qsat(h_ff.pk2);
      s3 = qsat(h_ff.pp1);
      s4 = qsat(h_ff.pp2);
      i_in.x    = h_ff.x;
      i_in.y    = h_ff.y;
      i_in.r2   = h_ff.r2;
      i_in.ax   = h_ff.ax;
      i_in.ay   = h_ff.ay;
      i_in.k1r2 = s1.val;
      i_in.k2r2 = s2.val;
      i_in.p1xy = s3.val;
      i_in.p2xy = s4.val;
      i_in.ovf  = h_ff.ovf || s1.ovf || s2.ovf || s3.ovf || s4.ovf;
      i_in.zero = h_ff.zero;
   end

   always_comb begin
      sat_type s1, s2;
      s1 = sat2(i_ff.p1xy);
      s2 = sat2(i_ff.p2xy);
      j_in.x    = i_ff.x;
      j_in.y    = i_ff.y;
      j_in.k1r2 = i_ff.k1r2;
      j_in.dp1  = s1.val;
      j_in.dp2  = s2.val;
      j_in.pt   = mul32(i_ff.k2r2, i_ff.r2);
      j_in.pax  = mul32(coef_ff[IDX_P2], i_ff.ax);
      j_in.pay  = mul32(coef_ff[IDX_P1], i_ff.ay);
      j_in.ovf  = i_ff.ovf || s1.ovf || s2.ovf;
      j_in.zero = i_ff.zero;
   end

   always_comb begin
      sat_type s1, s2, s3;
      s1 = qsat(j_ff.pt);
      s2 = qsat(j_ff.pax);
      s3 = qsat(j_ff.pay);
      k_in.x    = j_ff.x;
      k_in.y    = j_ff.y;
      k_in.k1r2 = j_ff.k1r2;
      k_in.dp1  = j_ff.dp1;
      k_in.dp2  = j_ff.dp2;
      k_in.t    = s1.val;
      k_in.pax  = s2.val;
      k_in.pay  = s3.val;
      k_in.ovf  = j_ff.ovf || s1.ovf || s2.ovf || s3.ovf;
      k_in.zero = j_ff.zero;
   end

   // radial factor 1 + k1 r2 + k2 r2^2
   always_comb begin
      sat_type srad;
      srad = sum3(q_type'(32'sd1 <<< FRAC), k_ff.k1r2, k_ff.t);
      l_in.x      = k_ff.x;
      l_in.y      = k_ff.y;
      l_in.radial = srad.val;
      l_in.dp1    = k_ff.dp1;
      l_in.dp2    = k_ff.dp2;
      l_in.pax    = k_ff.pax;
      l_in.pay    = k_ff.pay;
      l_in.ovf    = k_ff.ovf || srad.ovf;
      l_in.zero   = k_ff.zero;
   end

   always_comb begin
      m_in.pxr  = mul32(l_ff.x, l_ff.radial);
      m_in.pyr  = mul32(l_ff.y, l_ff.radial);
      m_in.dp1  = l_ff.dp1;
      m_in.dp2  = l_ff.dp2;
      m_in.pax  = l_ff.pax;
      m_in.pay  = l_ff.pay;
      m_in.ovf  = l_ff.ovf;
      m_in.zero = l_ff.zero;
   end

   always_comb begin
      sat_type s1, s2;
      s1 = qsat(m_ff.pxr);
      s2 = qsat(m_ff.pyr);
      n_in.xr   = s1.val;
      n_in.yr   = s2.val;
      n_in.dp1  = m_ff.dp1;
      n_in.dp2  = m_ff.dp2;
      n_in.pax  = m_ff.pax;
      n_in.pay  = m_ff.pay;
      n_in.ovf  = m_ff.ovf || s1.ovf || s2.ovf;
      n_in.zero = m_ff.zero;
   end

   // distorted normalised position
   always_comb begin
      sat_type sxd, syd;
      sxd = sum3(n_ff.xr, n_ff.dp1, n_ff.pax);
      syd = sum3(n_ff.yr, n_ff.pay, n_ff.dp2);
      o_in.xd   = sxd.val;
      o_in.yd   = syd.val;
      o_in.ovf  = n_ff.ovf || sxd.ovf || syd.ovf;
      o_in.zero = n_ff.zero;
   end

   always_comb begin
      p_in.pc   = mul32(coef_ff[IDX_FU], o_ff.xd);
      p_in.pr   = mul32(coef_ff[IDX_FV], o_ff.yd);
      p_in.ovf  = o_ff.ovf;
      p_in.zero = o_ff.zero;
   end

   // add the principal point, round to Q16.16; zero depth forces a flagged origin
   always_comb begin
      sat_type sc, sr;
      sc = toq16(p_ff.pc, coef_ff[IDX_CU]);
      sr = toq16(p_ff.pr, coef_ff[IDX_CV]);
      if (p_ff.zero) begin
         col_in = '0;
         row_in = '0;
         inv_in = 1'b1;
      end else begin
         col_in = sc.val;
         row_in = sr.val;
         inv_in = p_ff.ovf || sc.ovf || sr.ovf;
      end
   end

   // payload registers: no reset needed
   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      dl1_o_ff <= {dl1_o_ff[DIV_LAT-2:0], b_ff.oob};
      c_ff     <= c_in;
      d_ff     <= d_in;
      dl2_o_ff <= {dl2_o_ff[DIV_LAT-2:0], d_ff.ovf};
      dl2_z_ff <= {dl2_z_ff[DIV_LAT-2:0], (d_ff.rz == '0)};
      e_ff     <= e_in;
      f_ff     <= f_in;
      g_ff     <= g_in;
      h_ff     <= h_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      l_ff     <= l_in;
      m_ff     <= m_in;
      n_ff     <= n_in;
      o_ff     <= o_in;
      p_ff     <= p_in;
      col_ff   <= col_in;
      row_ff   <= row_in;
      inv_ff   <= inv_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_source_col = col_ff;
   assign rsp_source_row = row_ff;
   assign rsp_invalid    = inv_ff;

endmodule

// ----- hdl/rrc_checker.sv -----
module rrc_checker import rrc_pkg::*; (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_mode,
   input logic rsp_strobe
);

   logic [FLIGHT_W-1:0] pend_ff;
   logic [FLIGHT_W-1:0] pend_in;

   assign pend_in = pend_ff + FLIGHT_W'(start && !busy && (req_mode == MODE_MAP))
                    - FLIGHT_W'(rsp_strobe);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_busy_only_writes: assert property (@(posedge clock) disable iff (reset)
      busy |-> (req_mode == MODE_WRITE))
      else $error("busy raised against a map transaction");

   a_busy_needs_flight: assert property (@(posedge clock) disable iff (reset)
      busy |-> (pend_ff != '0))
      else $error("busy raised with nothing in flight");

   a_strobe_needs_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (pend_ff != '0))
      else $error("result without an outstanding map transaction");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobe straight after reset");

endmodule

bind rectify_remap_coordinate_unit rrc_checker u_rrc_checker (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

// Testbench for the rectified-to-raw coordinate mapper.
// A directed table walks the reset state, the coefficient-write path (including
// out-of-range indices), identity calibration and saturating extremes. A random phase
// follows: mostly plausible camera calibrations with random pixel positions, plus
// some noise writes with full-range or zero values. Every map transaction is predicted
// at acceptance and checked in order against the strobed results.
module tb_top;
   import rrc_pkg::*;

   localparam int  ITEMS_RANDOM = 1300;
   localparam int  QUIET_TAIL   = 200;
   localparam int  WATCHDOG_MAX = 4000;
   localparam int  DRAIN_WAIT   = 120;
   localparam int  WIDTH_MAX    = 2048;
   localparam int  HEIGHT_MAX   = 2048;
   localparam longint ONE_Q20   = 64'sd1 <<< FRAC;
   localparam longint LIM_HI    = 64'sd2147483647;
   localparam longint LIM_LO    = -64'sd2147483648;

   typedef struct packed {
      logic signed [31:0] col;
      logic signed [31:0] row;
      logic               inv;
   } source_type;

   typedef struct {
      logic               mode;
      logic [4:0]         idx;
      logic signed [31:0] val;
      logic [10:0]        col;
      logic [10:0]        row;
      bit                 typed;
      source_type         want;
   } stim_row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_mode;
   logic [4:0]         req_coef_index;
   logic signed [31:0] req_coef_value;
   logic [10:0]        req_pixel_col;
   logic [10:0]        req_pixel_row;
   logic               rsp_strobe;
   logic signed [31:0] rsp_source_col;
   logic signed [31:0] rsp_source_row;
   logic               rsp_invalid;

   // typed expectation travels with the transaction it belongs to
   bit                 typed_q;
   source_type         typed_want_q;

   logic signed [31:0] calib[COEF_COUNT];
   source_type         pending_maps[$];
   stim_row_type       directed[$];

   int fail_count, map_count, write_count, result_count, invalid_count;
   int idle_cycles;
   bit gaps_on;

   rectify_remap_coordinate_unit #(
      .IMAGE_WIDTH_MAX (WIDTH_MAX),
      .IMAGE_HEIGHT_MAX(HEIGHT_MAX)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .req_pixel_col  (req_pixel_col),
      .req_pixel_row  (req_pixel_row),
      .rsp_strobe     (rsp_strobe),
      .rsp_source_col (rsp_source_col),
      .rsp_source_row (rsp_source_row),
      .rsp_invalid    (rsp_invalid)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   function automatic longint clamp32(input longint v, inout bit o);
      if (v > LIM_HI) begin
         o = 1'b1;
         return LIM_HI;
      end
      if (v < LIM_LO) begin
         o = 1'b1;
         return LIM_LO;
      end
      return v;
   endfunction

   // round half up, then drop s fraction bits
   function automatic longint round_down(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint q20_mul(input longint a, input longint b, inout bit o);
      return clamp32(round_down(a * b, FRAC), o);
   endfunction

   // Q20 quotient, nearest with ties away from zero
   function automatic longint q20_div(input longint n, input longint d, inout bit o);
      longint un, ud, q;
      bit     neg;
      if (d == 0) begin
         o = 1'b1;
         if (n == 0) return 0;
         return (n > 0) ? LIM_HI : LIM_LO;
      end
      neg = (n < 0) != (d < 0);
      un  = ((n < 0) ? -n : n) <<< FRAC;
      ud  = (d < 0) ? -d : d;
      q   = (un + ud / 2) / ud;
      if (q > (64'sd1 <<< 40)) q = 64'sd1 <<< 40;
      return clamp32(neg ? -q : q, o);
   endfunction

   function automatic longint k(input int i);
      return longint'(calib[i]);
   endfunction

   function automatic source_type raw_position(input int col, input int row);
      source_type res;
      bit     o;
      longint xn, yn, rx, ry, rz, x, y, r2, radial, xy, xd, yd, t;
      o = (col >= WIDTH_MAX) || (row >= HEIGHT_MAX);
      xn = q20_div(longint'(col) * ONE_Q20 - k(IDX_CX), k(IDX_FX), o);
      yn = q20_div(longint'(row) * ONE_Q20 - k(IDX_CY), k(IDX_FY), o);
      // ray rotated by the transpose: column j of R dotted with (xn, yn, 1)
      rx = clamp32(round_down(k(IDX_R0) * xn, FRAC) + round_down(k(IDX_R3) * yn, FRAC)
                   + k(IDX_R6), o);
      ry = clamp32(round_down(k(IDX_R1) * xn, FRAC) + round_down(k(IDX_R4) * yn, FRAC)
                   + k(IDX_R7), o);
      rz = clamp32(round_down(k(IDX_R2) * xn, FRAC) + round_down(k(IDX_R5) * yn, FRAC)
                   + k(IDX_R8), o);
      if (rz == 0) begin
         res.col = '0;
         res.row = '0;
         res.inv = 1'b1;
         return res;
      end
      x  = q20_div(rx, rz, o);
      y  = q20_div(ry, rz, o);
      r2 = clamp32(q20_mul(x, x, o) + q20_mul(y, y, o), o);
      t  = q20_mul(q20_mul(k(IDX_K2), r2, o), r2, o);
      radial = clamp32(ONE_Q20 + q20_mul(k(IDX_K1), r2, o) + t, o);
      xy = q20_mul(x, y, o);
      xd = clamp32(q20_mul(x, radial, o)
                   + clamp32(2 * q20_mul(k(IDX_P1), xy, o), o)
                   + q20_mul(k(IDX_P2), clamp32(r2 + 2 * q20_mul(x, x, o), o), o), o);
      yd = clamp32(q20_mul(y, radial, o)
                   + q20_mul(k(IDX_P1), clamp32(r2 + 2 * q20_mul(y, y, o), o), o)
                   + clamp32(2 * q20_mul(k(IDX_P2), xy, o), o), o);
      res.col = 32'(clamp32(round_down(k(IDX_FU) * xd + k(IDX_CU) * ONE_Q20, Q16_SHIFT), o));
      res.row = 32'(clamp32(round_down(k(IDX_FV) * yd + k(IDX_CV) * ONE_Q20, Q16_SHIFT), o));
      res.inv = o;
      return res;
   endfunction

   // ---------------------------------------------------------------- monitors
   // Track accepted transactions: update the coefficient copy or queue a prediction.
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         if (req_mode == MODE_WRITE) begin
            write_count <= write_count + 1;
            if (req_coef_index < COEF_COUNT) calib[req_coef_index] = req_coef_value;
         end else begin
            map_count <= map_count + 1;
            if (typed_q) pending_maps.push_back(typed_want_q);
            else pending_maps.push_back(raw_position(int'(req_pixel_col),
                                                     int'(req_pixel_row)));
         end
      end
   end

   // Compare each strobed result with the oldest prediction.
   always @(posedge clock) begin
      source_type want;
      if (!reset && rsp_strobe) begin
         result_count <= result_count + 1;
         if (rsp_invalid) invalid_count <= invalid_count + 1;
         if (pending_maps.size() == 0) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10)
               $display("%0t: result with no map transaction outstanding", $realtime);
         end else begin
            want = pending_maps.pop_front();
            if (rsp_source_col !== want.col || rsp_source_row !== want.row ||
                rsp_invalid !== want.inv) begin
               fail_count = fail_count + 1;
               if (fail_count <= 10)
                  $display("%0t: mismatch col %h/%h row %h/%h invalid %b/%b (exp/act)",
                           $realtime, want.col, rsp_source_col, want.row, rsp_source_row,
                           want.inv, rsp_invalid);
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
         $display("rectify_remap_coordinate_unit verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- driver
   // Present one transaction and hold it until the block takes it, then maybe idle.
   task automatic issue(input logic mode, input logic [4:0] idx, input logic signed [31:0] val,
                        input logic [10:0] col, input logic [10:0] row,
                        input bit typed, input source_type want);
      req_mode       <= mode;
      req_coef_index <= idx;
      req_coef_value <= val;
      req_pixel_col  <= col;
      req_pixel_row  <= row;
      typed_q        <= typed;
      typed_want_q   <= want;
      start          <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (gaps_on && $urandom_range(0, 9) < 3) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic write_coef(input logic [4:0] idx, input logic signed [31:0] val);
      issue(MODE_WRITE, idx, val, 11'($urandom), 11'($urandom), 1'b0, '0);
   endtask

   task automatic map_pixel(input logic [10:0] col, input logic [10:0] row);
      issue(MODE_MAP, 5'($urandom), $urandom, col, row, 1'b0, '0);
   endtask

   function automatic logic signed [31:0] spread(input int centre, input int half);
      return centre + $signed($urandom_range(0, 2 * half)) - half;
   endfunction

   // A plausible camera: near-identity rotation, sensible focal lengths and centres.
   function automatic logic signed [31:0] plausible(input int i);
      case (i)
         IDX_R0, IDX_R4, IDX_R8: return spread(int'(ONE_Q20), int'(ONE_Q20 / 20));
         IDX_R1, IDX_R3, IDX_R6, IDX_R7: return spread(0, int'(ONE_Q20 / 10));
         IDX_R2, IDX_R5: return spread(0, int'(ONE_Q20 / 4000));
         IDX_FX, IDX_FY, IDX_FU, IDX_FV: return 32'($urandom_range(300, 1800) * ONE_Q20
                                              + $urandom_range(0, 32'(ONE_Q20 - 1)));
         IDX_CX, IDX_CY, IDX_CU, IDX_CV: return 32'($urandom_range(0, 2047) * ONE_Q20
                                              + $urandom_range(0, 32'(ONE_Q20 - 1)));
         IDX_K1: return spread(0, int'(ONE_Q20 / 3));
         IDX_K2: return spread(0, int'(ONE_Q20 / 10));
         default: return spread(0, int'(ONE_Q20 / 100));
      endcase
   endfunction

   task automatic add_row(input logic mode, input logic [4:0] idx,
                          input logic signed [31:0] val, input int col, input int row,
                          input bit typed, input source_type want);
      stim_row_type r;
      r.mode  = mode;
      r.idx   = idx;
      r.val   = val;
      r.col   = 11'(col);
      r.row   = 11'(row);
      r.typed = typed;
      r.want  = want;
      directed.push_back(r);
   endtask

   initial begin
      int sent;
      source_type dead, none, ident57;
      fail_count = 0;
      foreach (calib[i]) calib[i] = '0;
      gaps_on        = 1'b0;
      reset          = 1'b1;
      start          = 1'b0;
      typed_q        = 1'b0;
      typed_want_q   = '0;
      req_mode       = MODE_WRITE;
      req_coef_index = '0;
      req_coef_value = '0;
      req_pixel_col  = '0;
      req_pixel_row  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      dead    = '{col: 0, row: 0, inv: 1'b1};
      none    = '0;
      ident57 = '{col: 5 <<< 16, row: 7 <<< 16, inv: 1'b0};

      // cleared table: zero depth everywhere
      add_row(MODE_MAP, 0, 0, 0, 0, 1, dead);
      add_row(MODE_MAP, 0, 0, 2047, 2047, 1, dead);
      // index beyond the table: must change nothing
      add_row(MODE_WRITE, 31, 32'shFFFF_FFFF, 0, 0, 0, none);
      add_row(MODE_WRITE, 21, 32'sh7FFF_FFFF, 0, 0, 0, none);
      add_row(MODE_MAP, 0, 0, 1, 1, 1, dead);
      // identity camera
      add_row(MODE_WRITE, IDX_R0, ONE_Q20, 0, 0, 0, none);
      add_row(MODE_WRITE, IDX_R4, ONE_Q20, 0, 0, 0, none);
      add_row(MODE_WRITE, IDX_R8, ONE_Q20, 0, 0, 0, none);
      add_row(MODE_WRITE, IDX_FX, ONE_Q20, 0, 0, 0, none);
      add_row(MODE_WRITE, IDX_FY, ONE_Q20, 0, 0, 0, none);
      add_row(MODE_WRITE, IDX_FU, ONE_Q20, 0, 0, 0, none);
      add_row(MODE_WRITE, IDX_FV, ONE_Q20, 0, 0, 0, none);
      add_row(MODE_MAP, 0, 0, 5, 7, 1, ident57);
      // radius overflows the Q20 range
      add_row(MODE_MAP, 0, 0, 2047, 0, 0, none);
      // extreme distortion and offsets
      add_row(MODE_WRITE, IDX_K1, 32'sh8000_0000, 0, 0, 0, none);
      add_row(MODE_WRITE, IDX_K2, 32'sh7FFF_FFFF, 0, 0, 0, none);
      add_row(MODE_WRITE, IDX_P1, 32'sh7FFF_FFFF, 0, 0, 0, none);
      add_row(MODE_WRITE, IDX_P2, 32'sh8000_0000, 0, 0, 0, none);
      add_row(MODE_WRITE, IDX_CU, 32'sh7FFF_FFFF, 0, 0, 0, none);
      add_row(MODE_WRITE, IDX_CV, 32'sh8000_0000, 0, 0, 0, none);
      add_row(MODE_MAP, 0, 0, 3, 2, 0, none);
      // zero focal length: normalised coordinate saturates
      add_row(MODE_WRITE, IDX_FX, 0, 0, 0, 0, none);
      add_row(MODE_MAP, 0, 0, 3, 3, 0, none);
      add_row(MODE_MAP, 0, 0, 0, 3, 0, none);

      foreach (directed[i])
         issue(directed[i].mode, directed[i].idx, directed[i].val, directed[i].col,
               directed[i].row, directed[i].typed, directed[i].want);

      // random phase: batches of fresh calibration, noise writes and pixel maps
      sent = 0;
      while (sent < ITEMS_RANDOM) begin
         gaps_on = (ITEMS_RANDOM - sent > QUIET_TAIL) && ($urandom_range(0, 9) < 7);
         if ($urandom_range(0, 3) != 0) begin
            for (int i = 0; i < COEF_COUNT; i++) begin
               write_coef(5'(i), plausible(i));
               sent++;
            end
         end
         for (int n = $urandom_range(20, 60); n > 0; n--) begin
            if ($urandom_range(0, 19) == 0) write_coef(5'($urandom_range(0, 31)), $urandom);
            else if ($urandom_range(0, 29) == 0) write_coef(5'($urandom_range(0, 20)), 0);
            else map_pixel(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)));
            sent++;
         end
      end
      start <= 1'b0;

      // drain: wait for outstanding maps, then let the pipeline settle
      while (pending_maps.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Mapped %0d pixels and wrote %0d coefficients; %0d results, %0d invalid.",
               map_count, write_count, result_count, invalid_count);
      if (fail_count == 0) begin
         $display("rectify_remap_coordinate_unit verification clean");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("rectify_remap_coordinate_unit verification failed");
      end
      $finish;
   end

endmodule
